// ===== src/apw4_pkg.sv =====
package apw4_pkg;

  localparam int unsigned FpW = 32;
  localparam int unsigned IdxW = 2;
  localparam int unsigned WsW = 3;
  localparam int unsigned CfgAddrW = 2;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_WINDOW_SIZE = 2'd0,
    CFG_CLAMP_MAX   = 2'd1,
    CFG_CLAMP_MIN   = 2'd2
  } cfg_reg_e;

  localparam logic [WsW-1:0] WindowSizeRst = 3'd4;
  localparam logic [FpW-1:0] ClampMaxRst = 32'h7F80_0000;
  localparam logic [FpW-1:0] ClampMinRst = 32'hFF80_0000;

  typedef struct packed {
    logic [FpW-1:0] window_value_0;
    logic [FpW-1:0] window_value_1;
    logic [FpW-1:0] window_value_2;
    logic [FpW-1:0] window_value_3;
    logic           last_channel;
    logic           last_pixel;
  } in_word_t;

  typedef struct packed {
    logic [FpW-1:0]  max_value;
    logic [IdxW-1:0] winner_index;
    logic            last_channel_out;
    logic            last_pixel_out;
  } out_word_t;

  // Return a > b as IEEE singles; false when either is NaN.
  function automatic logic fp_gt(input logic [FpW-1:0] a, input logic [FpW-1:0] b);
    logic a_nan;
    logic b_nan;
    logic a_zero;
    logic b_zero;
    logic res;
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    if (a_nan || b_nan || (a_zero && b_zero)) begin
      res = 1'b0;
    end else if (a[31] != b[31]) begin
      res = b[31];
    end else if (!a[31]) begin
      res = a[30:0] > b[30:0];
    end else begin
      res = a[30:0] < b[30:0];
    end
    return res;
  endfunction

endpackage

// ===== src/apw4_stream_if.sv =====
interface apw4_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/argmax_pool_window4_clamped_core.sv =====
// Pipeline: a capture register, then one register per compare of values 1 to 3;
//   the clamp is combinational on the last register.
// Throughput: one word per cycle; the pipeline advances whenever the output
//   register is empty or being taken, so a full stall holds every stage.
// Reset: rst_ni clears all valid bits and loads window_size = 4,
//   clamp_max = +inf and clamp_min = -inf.
module argmax_pool_window4_clamped_core #(
  parameter int unsigned WINDOW_MAX = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [apw4_pkg::CfgAddrW-1:0] cfg_idx_i,
  input  logic [apw4_pkg::FpW-1:0]      cfg_wdata_i,
  apw4_stream_if.sink                   in_if,
  apw4_stream_if.source                 out_if
);

  localparam int unsigned NStg = 4;

  logic [apw4_pkg::WsW-1:0] window_size_q;
  logic [apw4_pkg::FpW-1:0] clamp_max_q;
  logic [apw4_pkg::FpW-1:0] clamp_min_q;
  logic [apw4_pkg::WsW-1:0] count;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= apw4_pkg::WindowSizeRst;
      clamp_max_q   <= apw4_pkg::ClampMaxRst;
      clamp_min_q   <= apw4_pkg::ClampMinRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        apw4_pkg::CFG_WINDOW_SIZE: window_size_q <= cfg_wdata_i[apw4_pkg::WsW-1:0];
        apw4_pkg::CFG_CLAMP_MAX:   clamp_max_q   <= cfg_wdata_i;
        apw4_pkg::CFG_CLAMP_MIN:   clamp_min_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Saturate the window size to 1..WINDOW_MAX
  always_comb begin
    if (window_size_q == '0) begin
      count = apw4_pkg::WsW'(1);
    end else if (window_size_q > apw4_pkg::WsW'(WINDOW_MAX)) begin
      count = apw4_pkg::WsW'(WINDOW_MAX);
    end else begin
      count = window_size_q;
    end
  end

  // Stage registers: stage s compares window value s against the best
  logic [NStg-1:0]                valid_q;
  logic [apw4_pkg::FpW-1:0]       best_q [NStg];
  logic [apw4_pkg::IdxW-1:0]      idx_q  [NStg];
  logic [2:0][apw4_pkg::FpW-1:0]  vals_q [NStg-1];
  logic [1:0]                     flags_q [NStg];
  logic [NStg-1:0]                adv;
  logic [apw4_pkg::FpW-1:0]       min_v;
  logic [apw4_pkg::FpW-1:0]       clamped;

  // Advance a stage when the one after it moves or it is empty
  always_comb begin
    adv[NStg-1] = !valid_q[NStg-1] || out_if.ready;
    for (int s = NStg - 2; s >= 0; s--) begin
      adv[s] = !valid_q[s] || adv[s+1];
    end
  end

  assign in_if.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= in_if.valid;
      for (int s = 1; s < NStg; s++) begin
        if (adv[s]) valid_q[s] <= valid_q[s-1];
      end
    end
  end

  // Stage 0 captures the word with value 0 as the starting best;
  // stages 1 to 3 each compare one more window value
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      best_q[0]  <= in_if.data.window_value_0;
      idx_q[0]   <= '0;
      vals_q[0]  <= {in_if.data.window_value_3, in_if.data.window_value_2,
                     in_if.data.window_value_1};
      flags_q[0] <= {in_if.data.last_channel, in_if.data.last_pixel};
    end
    for (int s = 1; s < NStg; s++) begin
      if (adv[s]) begin
        flags_q[s] <= flags_q[s-1];
        if ((apw4_pkg::WsW'(s) < count) &&
            apw4_pkg::fp_gt(vals_q[s-1][s-1], best_q[s-1])) begin
          best_q[s] <= vals_q[s-1][s-1];
          idx_q[s]  <= apw4_pkg::IdxW'(s);
        end else begin
          best_q[s] <= best_q[s-1];
          idx_q[s]  <= idx_q[s-1];
        end
      end
    end
    for (int s = 1; s < NStg - 1; s++) begin
      if (adv[s]) vals_q[s] <= vals_q[s-1];
    end
  end

  // Clamp: MINPS against clamp_max, then MAXPS against clamp_min
  assign min_v   = apw4_pkg::fp_gt(clamp_max_q, best_q[3]) ? best_q[3] : clamp_max_q;
  assign clamped = apw4_pkg::fp_gt(min_v, clamp_min_q) ? min_v : clamp_min_q;

  assign out_if.valid                 = valid_q[NStg-1];
  assign out_if.data.max_value        = clamped;
  assign out_if.data.winner_index     = idx_q[NStg-1];
  assign out_if.data.last_channel_out = flags_q[NStg-1][1];
  assign out_if.data.last_pixel_out   = flags_q[NStg-1][0];

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(idx_q[NStg-1]))
    else $error("result dropped under stall");
  a_in_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> valid_q[0])
    else $error("accepted word not captured");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.ready |-> in_if.ready)
    else $error("pipeline stalled with free output");
`endif

endmodule

// ===== tb/argmax_pool_window4_clamped_checker.sv =====
`timescale 1ns / 1ps

module argmax_pool_window4_clamped_checker
  import apw4_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_idx_i,
  input  logic [FpW-1:0]      cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_word_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_word_t           out_data_i,
  output int unsigned         fail_cnt_o,
  output int unsigned         pending_o
);

  logic [WsW-1:0] win_size_q;
  logic [FpW-1:0] clamp_hi_q;
  logic [FpW-1:0] clamp_lo_q;
  out_word_t      expected_words[$];

  // Strict IEEE greater-than; any NaN or a pair of zeros gives false.
  function automatic logic float_above(logic [FpW-1:0] a, logic [FpW-1:0] b);
    logic a_nan;
    logic b_nan;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
    if (a_nan || b_nan) return 1'b0;
    if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
    if (a[31] != b[31]) return b[31];
    if (!a[31]) return a[30:0] > b[30:0];
    return a[30:0] < b[30:0];
  endfunction

  // Compute the clamped window maximum and winning position for one word.
  function automatic out_word_t pool_window(in_word_t w);
    logic [FpW-1:0] vals[4];
    logic [FpW-1:0] best;
    logic [FpW-1:0] lo_clamped;
    int             count;
    out_word_t      r;
    vals[0] = w.window_value_0;
    vals[1] = w.window_value_1;
    vals[2] = w.window_value_2;
    vals[3] = w.window_value_3;
    count = win_size_q;
    if (count < 1) count = 1;
    if (count > 4) count = 4;
    best = vals[0];
    r.winner_index = '0;
    for (int k = 1; k < count; k++) begin
      if (float_above(vals[k], best)) begin
        best = vals[k];
        r.winner_index = IdxW'(k);
      end
    end
    // min against upper clamp: best only if strictly below
    lo_clamped = float_above(clamp_hi_q, best) ? best : clamp_hi_q;
    r.max_value = float_above(lo_clamped, clamp_lo_q) ? lo_clamped : clamp_lo_q;
    r.last_channel_out = w.last_channel;
    r.last_pixel_out = w.last_pixel;
    return r;
  endfunction

  assign pending_o = expected_words.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    out_word_t   e;
    int unsigned errs;
    errs = 0;
    if (!rst_ni) begin
      win_size_q <= WindowSizeRst;
      clamp_hi_q <= ClampMaxRst;
      clamp_lo_q <= ClampMinRst;
      fail_cnt_o <= 0;
      expected_words.delete();
    end else begin
      // track register writes
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_WINDOW_SIZE: win_size_q <= cfg_wdata_i[WsW-1:0];
          CFG_CLAMP_MAX:   clamp_hi_q <= cfg_wdata_i;
          CFG_CLAMP_MIN:   clamp_lo_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      // predict on input accept
      if (in_valid_i && in_ready_i) expected_words.push_back(pool_window(in_data_i));
      // compare on output accept
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word %h", out_data_i);
          errs = errs + 1;
        end else begin
          e = expected_words.pop_front();
          if (e.max_value !== out_data_i.max_value) begin
            $error("max_value exp %h got %h", e.max_value, out_data_i.max_value);
            errs = errs + 1;
          end
          if (e.winner_index !== out_data_i.winner_index) begin
            $error("winner_index exp %0d got %0d", e.winner_index,
                   out_data_i.winner_index);
            errs = errs + 1;
          end
          if (e.last_channel_out !== out_data_i.last_channel_out) begin
            $error("last_channel_out exp %0b got %0b", e.last_channel_out,
                   out_data_i.last_channel_out);
            errs = errs + 1;
          end
          if (e.last_pixel_out !== out_data_i.last_pixel_out) begin
            $error("last_pixel_out exp %0b got %0b", e.last_pixel_out,
                   out_data_i.last_pixel_out);
            errs = errs + 1;
          end
        end
      end
      fail_cnt_o <= fail_cnt_o + errs;
    end
  end

endmodule

// ===== tb/argmax_pool_window4_clamped_core_test.sv =====
`timescale 1ns / 1ps

module argmax_pool_window4_clamped_core_test;
  import apw4_pkg::*;

  localparam int unsigned StallLimit = 2000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_idx_i;
  logic [FpW-1:0]      cfg_wdata_i;
  int unsigned         fail_cnt;
  int unsigned         pending;
  int unsigned         idle_cycles;
  bit                  rx_enable;

  apw4_stream_if #(.word_t(in_word_t))  in_if ();
  apw4_stream_if #(.word_t(out_word_t)) out_if ();

  argmax_pool_window4_clamped_core u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  argmax_pool_window4_clamped_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i(in_if.valid), .in_ready_i(in_if.ready), .in_data_i(in_if.data),
    .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_data_i(out_if.data),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // Interesting single-precision patterns.
  function automatic logic [FpW-1:0] special_float();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return {1'b0, 8'hFF, 23'($urandom) | 23'd1};
      5: return {1'b1, 8'hFF, 23'($urandom) | 23'd1};
      6: return 32'h3F80_0000;
      7: return 32'hBF80_0000;
      8: return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
      9: return 32'h7F7F_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [FpW-1:0] rand_float();
    return ($urandom_range(0, 2) == 0) ? special_float() : $urandom;
  endfunction

  // Offer one word; valid stays high after the accept unless a gap follows.
  task automatic send_word(in_word_t w);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= w;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_random(int n);
    in_word_t w;
    repeat (n) begin
      w.window_value_0 = rand_float();
      w.window_value_1 = rand_float();
      w.window_value_2 = rand_float();
      w.window_value_3 = rand_float();
      // sometimes force ties between positions
      if ($urandom_range(0, 7) == 0) w.window_value_2 = w.window_value_1;
      w.last_channel = $urandom;
      w.last_pixel = $urandom;
      send_word(w);
    end
  endtask

  // Drop valid, hold until every expected word is back, then let it settle.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [FpW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: random stalls per word, with stall-free stretches.
  always @(posedge clk_i) begin
    int gap;
    if (rx_enable && out_if.valid && out_if.ready) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on accepted words.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_word_t w;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_WINDOW_SIZE;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b1;
    rx_enable = 1'b0;
    idle_cycles = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    rx_enable = 1'b1;

    // Directed words at reset settings: extremes, NaNs, zeros, ties.
    w = '{32'h0, 32'h8000_0000, 32'h0, 32'h8000_0000, 1'b0, 1'b0};
    send_word(w);
    w = '{32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0};
    send_word(w);
    w = '{32'h7FC0_0000, 32'h7F80_0000, 32'h3F80_0000, 32'h0, 1'b0, 1'b1};
    send_word(w);
    w = '{32'h3F80_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h4000_0000, 1'b1, 1'b1};
    send_word(w);
    w = '{32'hFF80_0000, 32'hFF80_0000, 32'h7F80_0000, 32'h7F80_0000, 1'b0, 1'b0};
    send_word(w);
    w = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0};
    send_word(w);
    w = '{32'hBF80_0000, 32'hC000_0000, 32'hBF80_0000, 32'h0000_0001, 1'b0, 1'b1};
    send_word(w);
    drain();

    // Window size zero, then each legal size, then sizes above the maximum.
    for (int ws = 0; ws < 8; ws++) begin
      write_reg(CFG_WINDOW_SIZE, FpW'(ws));
      w = '{32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h4080_0000, ws[0], ws[1]};
      send_word(w);
      drain();
    end

    // Clamp corners: NaN clamps, zero ties, inverted bounds.
    write_reg(CFG_WINDOW_SIZE, 32'd4);
    write_reg(CFG_CLAMP_MAX, 32'h0000_0000);
    write_reg(CFG_CLAMP_MIN, 32'h8000_0000);
    w = '{32'h8000_0000, 32'h0, 32'h3F80_0000, 32'hBF80_0000, 1'b0, 1'b0};
    send_word(w);
    w = '{32'hBF80_0000, 32'hC000_0000, 32'hC040_0000, 32'hFF80_0000, 1'b1, 1'b1};
    send_word(w);
    drain();
    write_reg(CFG_CLAMP_MAX, 32'h7FC0_0001);
    write_reg(CFG_CLAMP_MIN, 32'hFFC0_0002);
    w = '{32'h3F80_0000, 32'h7FC0_0000, 32'h0, 32'h0, 1'b0, 1'b1};
    send_word(w);
    drain();
    write_reg(CFG_CLAMP_MAX, 32'hBF80_0000);
    write_reg(CFG_CLAMP_MIN, 32'h3F80_0000);
    w = '{32'h4000_0000, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0};
    send_word(w);
    drain();
    write_reg(CFG_CLAMP_MAX, 32'hFFFF_FFFF);
    write_reg(CFG_CLAMP_MIN, 32'h0000_0000);
    w = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h1, 1'b0, 1'b0};
    send_word(w);
    drain();

    // Random phases, each with its own register settings.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_WINDOW_SIZE, 32'd4);
          write_reg(CFG_CLAMP_MAX, 32'h7F80_0000);
          write_reg(CFG_CLAMP_MIN, 32'hFF80_0000);
        end
        1: begin
          write_reg(CFG_WINDOW_SIZE, 32'd1);
          write_reg(CFG_CLAMP_MAX, 32'hFFFF_FFFF);
          write_reg(CFG_CLAMP_MIN, 32'h0000_0000);
        end
        2: begin
          write_reg(CFG_WINDOW_SIZE, 32'd7);
          write_reg(CFG_CLAMP_MAX, 32'h0000_0000);
          write_reg(CFG_CLAMP_MIN, 32'hFFFF_FFFF);
        end
        default: begin
          write_reg(CFG_WINDOW_SIZE, FpW'($urandom_range(0, 7)));
          write_reg(CFG_CLAMP_MAX, special_float());
          write_reg(CFG_CLAMP_MIN, special_float());
        end
      endcase
      send_random(150);
      // midway hold-off until all results are back
      if (ph == 5) drain();
      send_random(4);
      drain();
    end

    // Let any final words settle, then verdict.
    drain();
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/apw4_pkg.sv
src/apw4_stream_if.sv
src/argmax_pool_window4_clamped_core.sv
tb/argmax_pool_window4_clamped_checker.sv
tb/argmax_pool_window4_clamped_core_test.sv
